### design/tccw_pkg.sv
// constants and types for the tagged chunk chain walker
// no dependencies; imported by tagged_chunk_chain_walker
package tccw_pkg;

  // atom tag byte codes
  localparam logic [7:0] TAG_LEAD = 8'h4F;  // 'O'
  localparam logic [7:0] TAG_LOW  = 8'h41;  // 'A'
  localparam logic [7:0] TAG_HIGH = 8'h5A;  // 'Z'

  // atom header: four tag bytes then four length bytes
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned LEN_WIDTH    = 32;
  localparam int unsigned STEP_WIDTH   = LEN_WIDTH + 1;

  // header byte index
  typedef logic [2:0] hdr_idx_t;

  localparam hdr_idx_t IDX_TAG0 = 3'd0;
  localparam hdr_idx_t IDX_LEN0 = 3'd4;
  localparam hdr_idx_t IDX_LEN1 = 3'd5;
  localparam hdr_idx_t IDX_LEN2 = 3'd6;
  localparam hdr_idx_t IDX_LEN3 = 3'd7;

endpackage

### design/tagged_chunk_chain_walker.sv
// Tagged chunk chain walker.
// Input channel: in_valid_i / in_ready_o with data_byte_i, one file byte per
// word, in stream order from offset zero.
// Output channel: out_valid_o / out_ready_i with stopped_o and
// expected_size_o, exactly one result word per input byte, giving the
// sticky stop flag and the end offset of the last parsed atom, both as they
// stand after that byte.
// Each byte's result is registered in the output register, or in the skid register.
// Throughput: one byte per cycle while the skid register is empty; the walker
// state update is one compare of the position against the next atom start and two offset-wide adds.
// A two-entry result buffer (output register plus skid register) lets a
// byte be taken while a finished result still waits; when the receiver
// stalls and both entries are full, in_ready_o drops until a word is taken.
// Reset (rst_ni low, asynchronous) clears position, next atom start,
// header progress, the stop flag and the result buffer.
// Depends on tccw_pkg.
module tagged_chunk_chain_walker #(
  parameter int unsigned OFFSET_WIDTH = 48
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              data_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    stopped_o,
  output logic [OFFSET_WIDTH-1:0] expected_size_o
);
  import tccw_pkg::*;

  localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = {OFFSET_WIDTH{1'b1}};

  // walker state
  logic [OFFSET_WIDTH-1:0] pos_q, pos_d;
  logic [OFFSET_WIDTH-1:0] nas_q, nas_d;
  hdr_idx_t                hdr_q, hdr_d;
  logic [23:0]             len_q, len_d;
  logic                    stop_q, stop_d;

  // result buffer
  logic                    out_valid_q, skid_valid_q;
  logic                    out_stop_q, skid_stop_q;
  logic [OFFSET_WIDTH-1:0] out_size_q, skid_size_q;

  logic push, pop;
  logic in_header, tag_ok;
  logic [LEN_WIDTH-1:0]    full_len;
  logic [STEP_WIDTH-1:0]   step;
  logic [OFFSET_WIDTH:0]   sum;

  assign in_ready_o = !skid_valid_q;
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_q && out_ready_i;

  // header detection and end offset arithmetic
  assign in_header = (hdr_q != IDX_TAG0) || ((pos_q == nas_q) && (nas_q != OFF_MAX));
  assign tag_ok    = (hdr_q == IDX_TAG0) ? (data_byte_i == TAG_LEAD)
                   : (data_byte_i inside {[TAG_LOW:TAG_HIGH]});
  assign full_len  = {data_byte_i, len_q};
  assign step      = STEP_WIDTH'(HEADER_BYTES) + {1'b0, full_len};
  assign sum       = {1'b0, nas_q} + {{(OFFSET_WIDTH + 1 - STEP_WIDTH){1'b0}}, step};

  // next walker state for the byte at the input
  always_comb begin
    pos_d  = pos_q;
    nas_d  = nas_q;
    hdr_d  = hdr_q;
    len_d  = len_q;
    stop_d = stop_q;
    if (!stop_q) begin
      if (in_header) begin
        case (hdr_q)
          IDX_LEN0: begin
            len_d[7:0] = data_byte_i;
            hdr_d      = hdr_q + hdr_idx_t'(1);
          end
          IDX_LEN1: begin
            len_d[15:8] = data_byte_i;
            hdr_d       = hdr_q + hdr_idx_t'(1);
          end
          IDX_LEN2: begin
            len_d[23:16] = data_byte_i;
            hdr_d        = hdr_q + hdr_idx_t'(1);
          end
          IDX_LEN3: begin
            nas_d = sum[OFFSET_WIDTH] ? OFF_MAX : sum[OFFSET_WIDTH-1:0];
            hdr_d = IDX_TAG0;
            len_d = '0;
          end
          default: begin
            // tag bytes
            if (!tag_ok) begin
              stop_d = 1'b1;
              hdr_d  = IDX_TAG0;
              len_d  = '0;
            end else begin
              hdr_d = hdr_q + hdr_idx_t'(1);
            end
          end
        endcase
      end
      if (pos_q != OFF_MAX) begin
        pos_d = pos_q + OFFSET_WIDTH'(1);
      end
    end
  end

  // walker state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      nas_q  <= '0;
      hdr_q  <= IDX_TAG0;
      len_q  <= '0;
      stop_q <= 1'b0;
    end else if (push) begin
      pos_q  <= pos_d;
      nas_q  <= nas_d;
      hdr_q  <= hdr_d;
      len_q  <= len_d;
      stop_q <= stop_d;
    end
  end

  // result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // result buffer payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_stop_q <= skid_stop_q;
        out_size_q <= skid_size_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_stop_q <= stop_d;
        skid_size_q <= nas_d;
      end else begin
        out_stop_q <= stop_d;
        out_size_q <= nas_d;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stopped_o       = out_stop_q;
  assign expected_size_o = out_size_q;

`ifndef SYNTH
  // skid entry is only ever filled behind a waiting output word
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held without output word");

  // stop is sticky
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q)
    else $error("stop flag cleared");

  // expected end never moves backward
  a_size_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> nas_q >= $past(nas_q))
    else $error("next atom start decreased");

  // no header in progress once stopped
  a_no_header_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_q != IDX_TAG0) |-> !stop_q)
    else $error("header progress after stop");
`endif

endmodule
